### hdl/ft12_pkg.sv
package ft12_pkg;

  // Field widths of one beat
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned OFFSET_W  = 13;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BYTE  = 3'd0,
    OP_READ_BYTE  = 3'd1,
    OP_READ_ENTRY = 3'd2,
    OP_WRITE_ENTRY = 3'd3,
    OP_FREE_CHAIN = 3'd4
  } op_t;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

  // Entry marks and nibble masks
  localparam logic [CLUSTER_W-1:0] EOC_MARK   = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] ENTRY_MASK = 12'hFFF;
  localparam logic [BYTE_W-1:0]    LO_NIBBLE  = 8'h0F;
  localparam logic [BYTE_W-1:0]    HI_NIBBLE  = 8'hF0;
  localparam logic [BYTE_W-1:0]    BYTE_MASK  = 8'hFF;

endpackage

### hdl/ft12_store.sv
module ft12_store
  import ft12_pkg::*;
#(
  parameter int unsigned DEPTH = 6144,
  parameter int unsigned AW    = 13
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data
);

  // Table bytes, contents undefined until loaded
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/fat12_table_engine.sv
// FAT12 allocation table engine.
// Input channel in_*: one beat is one operation (in_tuser) with its cluster,
// entry value, byte offset and byte data in in_tdata. Output channel out_*:
// exactly one result beat per input beat, in order. cfg_wr_en writes the
// highest valid cluster number; write it only while no operation is pending.
// The table lives in one byte memory with one read and one write port and a
// registered read, so every entry access is a sequence of byte reads and
// writes. A free chain reads each freed entry low byte, then high byte,
// then writes it back with two byte writes on the single write port. The
// engine returns to idle at the edge that registers the result and takes
// no new beat before then.
// The result sits in an output register: while the receiver stalls the next
// beat is still accepted and worked on, and only the hand-over of its result
// waits for the register to empty.
// Reset clears the control state and sets the highest cluster to 4095; the
// table contents are undefined until loaded or written.
module fat12_table_engine
  import ft12_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg: highest_cluster
  input  logic                  cfg_wr_en,
  input  logic [CLUSTER_W-1:0]  cfg_wr_data,
  // in_tdata: cluster[11:0], entry_value[23:12], byte_offset[36:24],
  //           byte_data[44:37], zero pad[47:45]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: operation[2:0]
  input  logic [OP_W-1:0]       in_tuser,
  // out_tdata: read_value[11:0], byte_value[19:12], end_of_chain[20],
  //            freed_count[32:21], status[34:33], zero pad[39:35]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned STORE_BYTES = (3 * MAX_CLUSTERS + 1) / 2;
  localparam int unsigned AW          = $clog2(STORE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BYTE,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WALK,
    S_WR_MRG,
    S_WR_FIX,
    S_RESULT
  } state_t;

  state_t                state_r;
  logic [CLUSTER_W-1:0]  highest_cluster_r;

  // Latched beat
  op_t                   op_r;
  logic [CLUSTER_W-1:0]  cl_r;
  logic [CLUSTER_W-1:0]  val_r;
  logic [OFFSET_W-1:0]   off_r;
  logic [BYTE_W-1:0]     dat_r;

  // Working values and result fields
  logic [BYTE_W-1:0]     b0_r;
  logic [BYTE_W-1:0]     b1_r;
  logic [CLUSTER_W-1:0]  next_r;
  logic [CLUSTER_W-1:0]  rv_r;
  logic [BYTE_W-1:0]     bv_r;
  logic                  eoc_r;
  logic [CLUSTER_W-1:0]  cnt_r;
  logic [STATUS_W-1:0]   st_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // Memory port
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [BYTE_W-1:0]     rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [BYTE_W-1:0]     wr_data;

  logic [CLUSTER_W-1:0]  lim;
  logic [OFFSET_W-1:0]   half;
  logic [OFFSET_W-1:0]   pos_full;
  logic [AW-1:0]         ptr_lo;
  logic [AW-1:0]         ptr_hi;
  logic                  odd;
  logic                  off_ok;
  logic                  cl_bad;
  logic [CLUSTER_W-1:0]  entry;
  logic                  in_beat;
  logic                  out_free;

  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // Limit in force: smaller of the register and the table size
  assign lim = (highest_cluster_r > CLUSTER_W'(MAX_CLUSTERS - 1)) ?
               CLUSTER_W'(MAX_CLUSTERS - 1) : highest_cluster_r;

  // Entry c sits at byte 3*(c/2) + (c%2)
  assign odd      = cl_r[0];
  assign half     = {2'b00, cl_r[CLUSTER_W-1:1]};
  assign pos_full = half + {half[OFFSET_W-2:0], 1'b0} + {{(OFFSET_W-1){1'b0}}, odd};
  assign ptr_lo   = pos_full[AW-1:0];
  assign ptr_hi   = ptr_lo + {{(AW-1){1'b0}}, 1'b1};

  assign off_ok = ({1'b0, off_r} < (OFFSET_W+1)'(STORE_BYTES));
  assign cl_bad = (cl_r > lim);

  // Entry from low byte (registered) and high byte (read data)
  assign entry = odd ? {rd_data, b0_r[BYTE_W-1:4]} : {rd_data[3:0], b0_r};

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_lo;
    wr_en   = 1'b0;
    wr_addr = ptr_lo;
    wr_data = '0;
    unique case (state_r)
      S_DECODE: begin
        case (op_r)
          OP_LOAD_BYTE: begin
            wr_en   = off_ok;
            wr_addr = off_r[AW-1:0];
            wr_data = dat_r;
          end
          OP_READ_BYTE: begin
            rd_en   = off_ok;
            rd_addr = off_r[AW-1:0];
          end
          OP_READ_ENTRY: begin
            rd_en = (cl_r != '0) && !cl_bad;
          end
          OP_WRITE_ENTRY: begin
            // fetch the byte that shares a nibble with the neighbour entry
            rd_en   = !cl_bad;
            rd_addr = odd ? ptr_lo : ptr_hi;
          end
          default: ;
        endcase
      end
      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = ptr_hi;
      end
      S_RD2: begin
        // free: clear low byte part of the entry
        wr_en   = (op_r == OP_FREE_CHAIN);
        wr_addr = ptr_lo;
        wr_data = odd ? (b0_r & LO_NIBBLE) : '0;
      end
      S_WR1: begin
        wr_en   = 1'b1;
        wr_addr = ptr_hi;
        wr_data = odd ? '0 : (b1_r & HI_NIBBLE);
      end
      S_WALK: begin
        rd_en = (cl_r != '0) && (cl_r < EOC_MARK) && !cl_bad && (cnt_r < lim);
      end
      S_WR_MRG: begin
        wr_en = 1'b1;
        if (odd) begin
          wr_addr = ptr_lo;
          wr_data = (rd_data & LO_NIBBLE) | {val_r[3:0], 4'h0};
        end else begin
          wr_addr = ptr_hi;
          wr_data = (rd_data & HI_NIBBLE) | {4'h0, val_r[CLUSTER_W-1:8]};
        end
      end
      S_WR_FIX: begin
        wr_en = 1'b1;
        if (odd) begin
          wr_addr = ptr_hi;
          wr_data = val_r[CLUSTER_W-1:4];
        end else begin
          wr_addr = ptr_lo;
          wr_data = val_r[BYTE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  ft12_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Sequencer, result fields and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_tvalid_r      <= 1'b0;
      highest_cluster_r <= ENTRY_MASK;
    end else begin
      if (cfg_wr_en) begin
        highest_cluster_r <= cfg_wr_data;
      end
      // a new result in the same cycle is loaded below instead
      if (out_tvalid_r && out_tready && (state_r != S_RESULT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            op_r    <= op_t'(in_tuser);
            cl_r    <= in_tdata[11:0];
            val_r   <= in_tdata[23:12];
            off_r   <= in_tdata[36:24];
            dat_r   <= in_tdata[44:37];
            rv_r    <= '0;
            bv_r    <= '0;
            eoc_r   <= 1'b0;
            cnt_r   <= '0;
            st_r    <= ST_OK;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_r <= S_RESULT;
          case (op_r)
            OP_LOAD_BYTE: begin
              if (!off_ok) st_r <= ST_RANGE;
            end
            OP_READ_BYTE: begin
              if (off_ok) state_r <= S_BYTE;
              else        st_r    <= ST_RANGE;
            end
            OP_READ_ENTRY: begin
              if (cl_r == '0) begin
                // root sentinel
                rv_r  <= EOC_MARK;
                eoc_r <= 1'b1;
              end else if (cl_bad) begin
                st_r <= ST_RANGE;
              end else begin
                state_r <= S_RD1;
              end
            end
            OP_WRITE_ENTRY: begin
              if (cl_bad) st_r    <= ST_RANGE;
              else        state_r <= S_WR_MRG;
            end
            OP_FREE_CHAIN: begin
              state_r <= S_WALK;
            end
            default: ;
          endcase
        end
        S_BYTE: begin
          bv_r    <= rd_data;
          state_r <= S_RESULT;
        end
        S_RD1: begin
          b0_r    <= rd_data;
          state_r <= S_RD2;
        end
        S_RD2: begin
          if (op_r == OP_FREE_CHAIN) begin
            next_r  <= entry;
            b1_r    <= rd_data;
            state_r <= S_WR1;
          end else begin
            rv_r    <= entry;
            eoc_r   <= (entry >= EOC_MARK);
            state_r <= S_RESULT;
          end
        end
        S_WR1: begin
          cnt_r   <= cnt_r + 1'b1;
          cl_r    <= next_r;
          state_r <= S_WALK;
        end
        S_WALK: begin
          if ((cl_r == '0) || (cl_r >= EOC_MARK)) begin
            state_r <= S_RESULT;
          end else if (cl_bad) begin
            st_r    <= ST_RANGE;
            state_r <= S_RESULT;
          end else if (cnt_r >= lim) begin
            st_r    <= ST_LONG;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_RD1;
          end
        end
        S_WR_MRG: begin
          state_r <= S_WR_FIX;
        end
        S_WR_FIX: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {5'b0, st_r, cnt_r, eoc_r, bv_r, rv_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  // No write while waiting for a beat
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("table written while idle");

  // Read and write never hit the same byte in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write to the same byte");

  // Each completed write-back of a freed entry counts once
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("freed count did not advance");

  // End of chain flag agrees with the value shown
  a_eoc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[20]) |-> (out_tdata[11:0] >= EOC_MARK))
    else $error("end of chain flag without end mark");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ft12_pkg::*;

  // Store size for 4096 clusters: (3*4096+1)/2 bytes
  localparam int unsigned TABLE_BYTES   = 6144;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned OFFSET_TOP    = (1 << OFFSET_W) - 1;

  // Only the bytes of clusters 0 to FILL_TOP are filled; random phases keep
  // the limit and the byte reads inside them
  localparam logic [CLUSTER_W-1:0] FILL_TOP   = 12'd255;
  localparam int unsigned          FILL_BYTES = 384;

  // Operation codes the engine must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [CLUSTER_W-1:0] read_value;
    logic [BYTE_W-1:0]    byte_value;
    logic                 end_of_chain;
    logic [CLUSTER_W-1:0] freed_count;
    logic [STATUS_W-1:0]  status;
  } fat_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CLUSTER_W-1:0]  cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Mirror of the table and of the highest cluster register
  logic [BYTE_W-1:0]     fat_image [TABLE_BYTES];
  logic [CLUSTER_W-1:0]  top_cluster;
  fat_result_t           fat_results_due [$];

  int unsigned fail_count  = 0;
  int unsigned beats_sent  = 0;
  int unsigned cycle_count = 0;
  bit          steady_flow = 1'b1;

  fat12_table_engine #(
    .MAX_CLUSTERS (4096)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Gap before a beat; zero throughout a steady stretch
  function automatic int unsigned draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 15);
  endfunction

  // Byte offset inside the filled bytes or past the end of the store
  function automatic logic [OFFSET_W-1:0] draw_offset();
    if ($urandom_range(0, 3) == 0) return OFFSET_W'($urandom_range(TABLE_BYTES, OFFSET_TOP));
    return OFFSET_W'($urandom_range(0, FILL_BYTES - 1));
  endfunction

  // ---------------------------------------------------------------------
  // Table mirror: entry c sits at byte 3*(c/2) + c%2
  // ---------------------------------------------------------------------
  function automatic int unsigned entry_base(input logic [CLUSTER_W-1:0] c);
    return 3 * int'(c >> 1) + int'(c[0]);
  endfunction

  function automatic logic [CLUSTER_W-1:0] fetch_entry(input logic [CLUSTER_W-1:0] c);
    int unsigned p;
    logic [15:0] pair;
    p    = entry_base(c);
    pair = {fat_image[p+1], fat_image[p]};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  // Nibble merge: odd entries own the high nibble of the first byte,
  // even entries the low nibble of the second
  function automatic void store_entry(input logic [CLUSTER_W-1:0] c,
                                      input logic [CLUSTER_W-1:0] v);
    int unsigned p;
    p = entry_base(c);
    if (c[0]) begin
      fat_image[p]   = {v[3:0], fat_image[p][3:0]};
      fat_image[p+1] = v[11:4];
    end else begin
      fat_image[p]   = v[7:0];
      fat_image[p+1] = {fat_image[p+1][7:4], v[11:8]};
    end
  endfunction

  // Expected result of one operation; updates the mirror as the engine would
  function automatic fat_result_t predict_fat_op(input logic [OP_W-1:0]      op,
                                                 input logic [CLUSTER_W-1:0] cl,
                                                 input logic [CLUSTER_W-1:0] val,
                                                 input logic [OFFSET_W-1:0]  off,
                                                 input logic [BYTE_W-1:0]    dat);
    fat_result_t r;
    logic [CLUSTER_W-1:0] walk;
    logic [CLUSTER_W-1:0] nxt;
    int unsigned cnt;
    r   = '{default: '0};
    cnt = 0;
    case (op)
      OP_LOAD_BYTE: begin
        if (off < TABLE_BYTES) fat_image[off] = dat;
        else r.status = ST_RANGE;
      end
      OP_READ_BYTE: begin
        if (off < TABLE_BYTES) r.byte_value = fat_image[off];
        else r.status = ST_RANGE;
      end
      OP_READ_ENTRY: begin
        // cluster 0 is the root sentinel and never touches the store
        if (cl == '0) r.read_value = EOC_MARK;
        else if (cl > top_cluster) r.status = ST_RANGE;
        else r.read_value = fetch_entry(cl);
        r.end_of_chain = (r.read_value >= EOC_MARK);
      end
      OP_WRITE_ENTRY: begin
        if (cl > top_cluster) r.status = ST_RANGE;
        else store_entry(cl, val);
      end
      OP_FREE_CHAIN: begin
        walk = cl;
        while (walk != '0 && walk < EOC_MARK) begin
          if (walk > top_cluster) begin
            r.status = ST_RANGE;
            break;
          end
          if (cnt >= top_cluster) begin
            r.status = ST_LONG;
            break;
          end
          nxt = fetch_entry(walk);
          store_entry(walk, '0);
          cnt++;
          walk = nxt;
        end
        r.freed_count = CLUSTER_W'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  task automatic issue_op(input logic [OP_W-1:0]      op,
                          input logic [CLUSTER_W-1:0] cl,
                          input logic [CLUSTER_W-1:0] val,
                          input logic [OFFSET_W-1:0]  off,
                          input logic [BYTE_W-1:0]    dat);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({dat, off, val, cl});
    do @(posedge clk); while (in_tready !== 1'b1);
    fat_results_due.push_back(predict_fat_op(op, cl, val, off, dat));
    beats_sent++;
  endtask

  // Unused fields carry random junk that the engine must ignore
  task automatic load_byte(input logic [OFFSET_W-1:0] off, input logic [BYTE_W-1:0] dat);
    issue_op(OP_LOAD_BYTE, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             CLUSTER_W'($urandom_range(0, ENTRY_MASK)), off, dat);
  endtask

  task automatic read_byte(input logic [OFFSET_W-1:0] off);
    issue_op(OP_READ_BYTE, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             CLUSTER_W'($urandom_range(0, ENTRY_MASK)), off,
             BYTE_W'($urandom_range(0, BYTE_MASK)));
  endtask

  task automatic read_entry(input logic [CLUSTER_W-1:0] cl);
    issue_op(OP_READ_ENTRY, cl, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             OFFSET_W'($urandom_range(0, OFFSET_TOP)), BYTE_W'($urandom_range(0, BYTE_MASK)));
  endtask

  task automatic write_entry(input logic [CLUSTER_W-1:0] cl, input logic [CLUSTER_W-1:0] val);
    issue_op(OP_WRITE_ENTRY, cl, val, OFFSET_W'($urandom_range(0, OFFSET_TOP)),
             BYTE_W'($urandom_range(0, BYTE_MASK)));
  endtask

  task automatic free_chain(input logic [CLUSTER_W-1:0] cl);
    issue_op(OP_FREE_CHAIN, cl, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             OFFSET_W'($urandom_range(0, OFFSET_TOP)), BYTE_W'($urandom_range(0, BYTE_MASK)));
  endtask

  // Stop sending and wait until the engine has handed back everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (fat_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the engine idle
  task automatic set_top_cluster(input logic [CLUSTER_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    top_cluster = v;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random back-pressure and field-by-field compare
  // ---------------------------------------------------------------------
  initial begin : result_check
    fat_result_t want;
    logic [OUT_DATA_W-1:0] got;
    int unsigned gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got = out_tdata;
      if (fat_results_due.size() == 0) begin
        $error("result beat %h with no operation outstanding", got);
        fail_count++;
      end else begin
        want = fat_results_due.pop_front();
        if (got[11:0] !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got[11:0]);
          fail_count++;
        end
        if (got[19:12] !== want.byte_value) begin
          $error("byte_value: expected %h, got %h", want.byte_value, got[19:12]);
          fail_count++;
        end
        if (got[20] !== want.end_of_chain) begin
          $error("end_of_chain: expected %b, got %b", want.end_of_chain, got[20]);
          fail_count++;
        end
        if (got[32:21] !== want.freed_count) begin
          $error("freed_count: expected %0d, got %0d", want.freed_count, got[32:21]);
          fail_count++;
        end
        if (got[34:33] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got[34:33]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Write the bytes of the low clusters so that no later read sees an
  // unwritten location
  task automatic fill_table();
    int unsigned a;
    steady_flow = 1'b1;
    for (a = 0; a < FILL_BYTES; a++)
      load_byte(OFFSET_W'(a), BYTE_W'($urandom_range(0, BYTE_MASK)));
    drain_results();
  endtask

  task automatic test_byte_access();
    steady_flow = 1'b0;
    load_byte('0, BYTE_MASK);
    read_byte('0);
    load_byte(OFFSET_W'(TABLE_BYTES - 1), '0);
    read_byte(OFFSET_W'(TABLE_BYTES - 1));
    // just past the store, and the top of the offset field
    load_byte(OFFSET_W'(TABLE_BYTES), 8'hA5);
    read_byte(OFFSET_W'(OFFSET_TOP));
    drain_results();
  endtask

  task automatic test_entry_access();
    write_entry(12'd2, 12'hABC);
    write_entry(12'd3, 12'h123);
    read_entry(12'd3);
    read_byte(13'd4);          // byte shared by entries 2 and 3
    // byte shared by the top entry and its neighbour
    load_byte(OFFSET_W'(TABLE_BYTES - 2), BYTE_W'($urandom_range(0, BYTE_MASK)));
    write_entry(ENTRY_MASK, ENTRY_MASK);
    read_entry(ENTRY_MASK);    // end of chain mark
    read_entry('0);            // root sentinel
    write_entry('0, 12'h5A5);  // raw write of entry 0
    read_entry(12'd1);
    drain_results();
    set_top_cluster(12'd100);
    read_entry(12'd101);
    write_entry(12'd101, 12'h777);
    drain_results();
  endtask

  task automatic test_free_chain();
    set_top_cluster(ENTRY_MASK);
    write_entry(12'd10, 12'd11);
    write_entry(12'd11, EOC_MARK);
    free_chain(12'd10);
    free_chain('0);                  // nothing to free
    free_chain(EOC_MARK + 12'd1);    // start already past the end mark
    drain_results();
    // walk runs into a cluster above the limit
    set_top_cluster(12'd100);
    write_entry(12'd20, 12'd4000);
    free_chain(12'd20);
    drain_results();
    // loop through every valid cluster: walk longer than the limit
    set_top_cluster(12'd4);
    write_entry(12'd1, 12'd2);
    write_entry(12'd2, 12'd3);
    write_entry(12'd3, 12'd4);
    write_entry(12'd4, 12'd1);
    free_chain(12'd1);
    drain_results();
  endtask

  task automatic test_spare_codes();
    logic [OP_W-1:0] op;
    for (op = OP_SPARE_LO; op != OP_SPARE_HI; op++)
      issue_op(op, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
               CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
               OFFSET_W'($urandom_range(0, OFFSET_TOP)), BYTE_W'($urandom_range(0, BYTE_MASK)));
    issue_op(OP_SPARE_HI, CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             CLUSTER_W'($urandom_range(0, ENTRY_MASK)),
             OFFSET_W'($urandom_range(0, OFFSET_TOP)), BYTE_W'($urandom_range(0, BYTE_MASK)));
    drain_results();
  endtask

  // Build a short chain, peek at it, then free it or a random cluster
  task automatic chain_scenario();
    logic [CLUSTER_W-1:0] links [6];
    logic [CLUSTER_W-1:0] tail;
    int unsigned len;
    int unsigned k;
    len = $urandom_range(1, 6);
    for (k = 0; k < len; k++) links[k] = CLUSTER_W'($urandom_range(1, top_cluster));
    case ($urandom_range(0, 3))
      0:       tail = '0;
      1, 2:    tail = CLUSTER_W'($urandom_range(EOC_MARK, ENTRY_MASK));
      default: tail = CLUSTER_W'($urandom_range(1, ENTRY_MASK));  // runs on into the table
    endcase
    for (k = 0; k < len; k++) write_entry(links[k], (k + 1 < len) ? links[k+1] : tail);
    repeat ($urandom_range(0, 2)) read_entry(links[$urandom_range(0, len - 1)]);
    if ($urandom_range(0, 4) != 0) free_chain(links[0]);
    else free_chain(CLUSTER_W'($urandom_range(0, ENTRY_MASK)));
  endtask

  // Anything goes, spare codes and out-of-range fields included
  task automatic noise_op();
    logic [OP_W-1:0] op;
    logic [CLUSTER_W-1:0] cl;
    if ($urandom_range(0, 9) == 0) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else op = OP_W'($urandom_range(OP_LOAD_BYTE, OP_FREE_CHAIN));
    if ($urandom_range(0, 1) == 0) cl = CLUSTER_W'($urandom_range(0, top_cluster));
    else cl = CLUSTER_W'($urandom_range(0, ENTRY_MASK));
    issue_op(op, cl, CLUSTER_W'($urandom_range(0, ENTRY_MASK)), draw_offset(),
             BYTE_W'($urandom_range(0, BYTE_MASK)));
  endtask

  task automatic test_random_phase(input logic [CLUSTER_W-1:0] limit,
                                   input int unsigned beats);
    int unsigned target;
    set_top_cluster(limit);
    target = beats_sent + beats;
    while (beats_sent < target) begin
      if ($urandom_range(0, 31) == 0) steady_flow = !steady_flow;
      if ($urandom_range(0, 9) < 6) chain_scenario();
      else noise_op();
    end
    drain_results();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_LOAD_BYTE;
    top_cluster = ENTRY_MASK;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_table();
    test_byte_access();
    test_entry_access();
    test_free_chain();
    test_spare_codes();
    test_random_phase(FILL_TOP, 130);
    test_random_phase(12'd2, 120);
    test_random_phase(CLUSTER_W'($urandom_range(3, 40)), 120);
    test_random_phase(CLUSTER_W'($urandom_range(41, FILL_TOP - 1)), 120);
    test_random_phase(FILL_TOP, 130);

    drain_results();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
